// File: design/mft_pkg.sv
// mft_pkg: shared types, codes and constants of the motor feedback tracker
`timescale 1ns / 1ps

package mft_pkg;

   localparam int EncoderCountsDefault = 8192;

   localparam int FuncW     = 2;
   localparam int FrameW    = 56;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;
   localparam int AlphaW    = 9;
   localparam int TimeoutW  = 16;
   localparam int FilterW   = 24;
   localparam int RspDataW  = 152;

   localparam logic [FuncW-1:0] FUNC_FRAME = 2'd0;
   localparam logic [FuncW-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_ZERO  = 2'd2;

   localparam logic [CsrIndexW-1:0] CSR_SPEED_ALPHA = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_TIMEOUT_MS  = 2'd1;

   localparam logic [AlphaW-1:0]   ALPHA_RESET   = 9'd77;
   localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd100;

   typedef struct packed {
      logic [FuncW-1:0]  func;
      logic [FrameW-1:0] frame_word;
   } item_type;

   typedef struct packed {
      logic [AlphaW-1:0]   speed_alpha;
      logic [TimeoutW-1:0] timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic               online;
      logic [31:0]        frame_count;
      logic signed [31:0] angle_total;
      logic [7:0]         temperature;
      logic signed [15:0] current_raw;
      logic signed [FilterW-1:0] speed_filtered;
      logic signed [15:0] speed_rpm;
      logic [15:0]        angle_raw;
   } status_type;

endpackage

// File: design/motor_feedback_tracker.sv
// motor_feedback_tracker: top level with input stage, update core and result register
// an accepted item is held in the input register, then its status is registered in the result register
// throughput: one item per cycle while no result is stalled, as the running state updates per item
// the input register and result register let the next item in while a result waits
// reset: synchronous active high, clears all tracker state, alpha to 77, timeout to 100
`timescale 1ns / 1ps

module motor_feedback_tracker #(
   parameter int ENCODER_COUNTS = mft_pkg::EncoderCountsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mft_pkg::FrameW-1:0]      req_tdata,  // frame_word
   input  logic [mft_pkg::FuncW-1:0]       req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // angle_raw, speed_rpm, speed_filtered, current_raw, temperature,
   // angle_total, frame_count, online, zero fill
   output logic [mft_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mft_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [mft_pkg::CsrDataW-1:0]    csr_wdata
);
   import mft_pkg::*;

   localparam int StatW = $bits(status_type);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   cfg_type    cfg_ff;
   status_type stat_cur;
   status_type stat_next;
   logic       rsp_valid_ff;
   status_type rsp_stat_ff;

   assign req_item.func       = req_tuser;
   assign req_item.frame_word = req_tdata;

   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   mft_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mft_core #(
      .ENCODER_COUNTS (ENCODER_COUNTS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .cfg       (cfg_ff),
      .stat_cur  (stat_cur),
      .stat_next (stat_next)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_alpha <= ALPHA_RESET;
         cfg_ff.timeout_ms  <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_ALPHA: cfg_ff.speed_alpha <= csr_wdata[AlphaW-1:0];
            CSR_TIMEOUT_MS:  cfg_ff.timeout_ms  <= csr_wdata[TimeoutW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_stat_ff <= stat_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - StatW){1'b0}}, rsp_stat_ff};

   a_frame_online: assert property (@(posedge clock) disable iff (reset)
      advance && item.func == FUNC_FRAME |=> rsp_tvalid && rsp_tdata[144])
      else $error("frame item did not raise online");

   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      advance && item.func == FUNC_FRAME
      |=> rsp_tdata[143:112] == $past(stat_cur.frame_count) + 32'd1)
      else $error("frame count did not step by one");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      advance && item.func == FUNC_ZERO |=> rsp_tdata[111:80] == 32'd0)
      else $error("zero command left accumulated angle");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending item changed or dropped while stalled");

endmodule

// File: design/mft_in_stage.sv
// mft_in_stage: input register holding one item for the update logic
`timescale 1ns / 1ps

module mft_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mft_pkg::item_type in_item,
   input  logic              advance,
   output logic              item_valid,
   output mft_pkg::item_type item
);
   import mft_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// File: design/mft_speed_filter.sv
// mft_speed_filter: first-order low-pass step in q.8 with saturation
`timescale 1ns / 1ps

module mft_speed_filter (
   input  logic signed [15:0]                  rpm,
   input  logic signed [mft_pkg::FilterW-1:0]  state,
   input  logic [mft_pkg::AlphaW-1:0]          alpha,
   output logic signed [mft_pkg::FilterW-1:0]  state_next
);
   import mft_pkg::*;

   localparam logic signed [27:0] SatMax = 28'sd8388607;
   localparam logic signed [27:0] SatMin = -28'sd8388608;

   logic signed [24:0] diff;
   logic signed [34:0] prod;
   logic signed [26:0] step;
   logic signed [27:0] sum;

   always_comb begin
      diff = 25'($signed({rpm, 8'd0})) - 25'(state);
      prod = 35'(diff) * 35'($signed({1'b0, alpha}));
      step = prod[34:8];
      sum  = 28'(step) + 28'(state);
      if (sum > SatMax) begin
         state_next = SatMax[FilterW-1:0];
      end else if (sum < SatMin) begin
         state_next = SatMin[FilterW-1:0];
      end else begin
         state_next = sum[FilterW-1:0];
      end
   end

endmodule

// File: design/mft_core.sv
// mft_core: tracker state and its update for one item
`timescale 1ns / 1ps

module mft_core #(
   parameter int ENCODER_COUNTS = mft_pkg::EncoderCountsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mft_pkg::item_type   item,
   input  mft_pkg::cfg_type    cfg,
   output mft_pkg::status_type stat_cur,
   output mft_pkg::status_type stat_next
);
   import mft_pkg::*;

   localparam logic signed [17:0] EncCounts = 18'(ENCODER_COUNTS);
   localparam logic signed [17:0] EncHalf   = 18'(ENCODER_COUNTS / 2);

   status_type stat_ff;
   logic       baseline_ff;
   logic       baseline_in;
   logic [31:0] time_ff;
   logic [31:0] time_in;
   logic [31:0] rx_time_ff;
   logic [31:0] rx_time_in;

   logic [15:0]        ang;
   logic signed [15:0] spd;
   logic signed [15:0] cur;
   logic [15:0]        ang_diff;
   logic signed [17:0] delta_a;
   logic signed [17:0] delta_b;
   logic signed [17:0] delta;
   logic signed [FilterW-1:0] filt_next;
   logic [31:0]        elapsed;

   assign ang = item.frame_word[55:40];
   assign spd = $signed(item.frame_word[39:24]);
   assign cur = $signed(item.frame_word[23:8]);

   mft_speed_filter u_filter (
      .rpm        (spd),
      .state      (stat_ff.speed_filtered),
      .alpha      (cfg.speed_alpha),
      .state_next (filt_next)
   );

   always_comb begin
      ang_diff = ang - stat_ff.angle_raw;
      delta_a  = 18'($signed(ang_diff));
      delta_b  = (delta_a > EncHalf) ? delta_a - EncCounts : delta_a;
      delta    = (delta_b < -EncHalf) ? delta_b + EncCounts : delta_b;
      time_in  = time_ff + 32'd1;
      elapsed  = time_in - rx_time_ff;
   end

   always_comb begin
      stat_next   = stat_ff;
      baseline_in = baseline_ff;
      rx_time_in  = rx_time_ff;
      case (item.func)
         FUNC_FRAME: begin
            if (baseline_ff) begin
               stat_next.angle_total = stat_ff.angle_total + 32'(delta);
            end
            baseline_in              = 1'b1;
            stat_next.angle_raw      = ang;
            stat_next.speed_filtered = filt_next;
            stat_next.speed_rpm      = spd;
            stat_next.current_raw    = cur;
            stat_next.temperature    = item.frame_word[7:0];
            rx_time_in               = time_ff;
            stat_next.frame_count    = stat_ff.frame_count + 32'd1;
            stat_next.online         = 1'b1;
         end
         FUNC_TICK: begin
            if (elapsed > {16'd0, cfg.timeout_ms}) begin
               stat_next.online = 1'b0;
            end
         end
         FUNC_ZERO: begin
            stat_next.angle_total = '0;
         end
         default: begin
         end
      endcase
   end

   assign stat_cur = stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff     <= '0;
         baseline_ff <= 1'b0;
         time_ff     <= '0;
         rx_time_ff  <= '0;
      end else if (advance) begin
         stat_ff     <= stat_next;
         baseline_ff <= baseline_in;
         rx_time_ff  <= rx_time_in;
         if (item.func == FUNC_TICK) begin
            time_ff <= time_in;
         end
      end
   end

endmodule

// File: tb/mft_status_checker.sv
// mft_status_checker: predicts the tracker status for every accepted item and compares result items
`timescale 1ns / 1ps

module mft_status_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mft_pkg::FrameW-1:0]      req_tdata,  // frame_word
   input  logic [mft_pkg::FuncW-1:0]       req_tuser,  // func
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // angle_raw, speed_rpm, speed_filtered, current_raw, temperature,
   // angle_total, frame_count, online, zero fill
   input  logic [mft_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mft_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [mft_pkg::CsrDataW-1:0]    csr_wdata,
   output int                              mismatches,
   output int                              pending
);
   import mft_pkg::*;

   localparam longint FilterMax = 8388607;
   localparam longint FilterMin = -8388608;

   logic [AlphaW-1:0]         alpha;
   logic [TimeoutW-1:0]       timeout;
   logic [15:0]               last_angle_q;
   bit                        baseline_seen;
   logic [31:0]               accum;
   logic signed [FilterW-1:0] filt;
   logic signed [15:0]        speed_q;
   logic signed [15:0]        current_q;
   logic [7:0]                temp_q;
   logic [31:0]               now_ms;
   logic [31:0]               rx_stamp;
   logic [31:0]               frames;
   bit                        online_q;

   status_type status_expected[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic logic signed [FilterW-1:0] low_pass_step(
      input logic signed [FilterW-1:0] state,
      input logic signed [15:0]        rpm,
      input logic [AlphaW-1:0]         coef
   );
      longint diff;
      longint nxt;
      diff = longint'(rpm) * 256 - longint'(state);
      // floor division by 256 is an arithmetic shift
      nxt = longint'(state) + ((diff * longint'(coef)) >>> 8);
      if (nxt > FilterMax) nxt = FilterMax;
      if (nxt < FilterMin) nxt = FilterMin;
      return FilterW'(nxt);
   endfunction

   task automatic clear_tracker();
      alpha         = ALPHA_RESET;
      timeout       = TIMEOUT_RESET;
      last_angle_q  = '0;
      baseline_seen = 0;
      accum         = '0;
      filt          = '0;
      speed_q       = '0;
      current_q     = '0;
      temp_q        = '0;
      now_ms        = '0;
      rx_stamp      = '0;
      frames        = '0;
      online_q      = 0;
      status_expected.delete();
   endtask

   task automatic advance_tracker(input logic [FuncW-1:0] f, input logic [FrameW-1:0] w);
      logic [15:0] ang;
      logic [15:0] wrapped;
      int          delta;
      status_type  s;
      case (f)
         FUNC_FRAME: begin
            ang = w[55:40];
            if (baseline_seen) begin
               wrapped = ang - last_angle_q;
               delta   = int'(signed'(wrapped));
               if (delta > EncoderCountsDefault / 2) delta -= EncoderCountsDefault;
               if (delta < -(EncoderCountsDefault / 2)) delta += EncoderCountsDefault;
               accum = accum + delta;
            end
            baseline_seen = 1;
            last_angle_q  = ang;
            filt          = low_pass_step(filt, w[39:24], alpha);
            speed_q       = w[39:24];
            current_q     = w[23:8];
            temp_q        = w[7:0];
            rx_stamp      = now_ms;
            frames        = frames + 1;
            online_q      = 1;
         end
         FUNC_TICK: begin
            now_ms = now_ms + 1;
            if (now_ms - rx_stamp > 32'(timeout)) online_q = 0;
         end
         FUNC_ZERO: begin
            accum = '0;
         end
         default: begin
         end
      endcase
      s.angle_raw      = last_angle_q;
      s.speed_rpm      = speed_q;
      s.speed_filtered = filt;
      s.current_raw    = current_q;
      s.temperature    = temp_q;
      s.angle_total    = accum;
      s.frame_count    = frames;
      s.online         = online_q;
      status_expected.push_back(s);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_status(input logic [RspDataW-1:0] data);
      status_type got;
      status_type want;
      got = data[$bits(status_type)-1:0];
      if (status_expected.size() == 0) begin
         $error("result item arrived with no expected status waiting");
         mismatches++;
      end else begin
         want = status_expected.pop_front();
         check_field("angle_raw", want.angle_raw, got.angle_raw);
         check_field("speed_rpm", want.speed_rpm, got.speed_rpm);
         check_field("speed_filtered", want.speed_filtered, got.speed_filtered);
         check_field("current_raw", want.current_raw, got.current_raw);
         check_field("temperature", want.temperature, got.temperature);
         check_field("angle_total", want.angle_total, got.angle_total);
         check_field("frame_count", want.frame_count, got.frame_count);
         check_field("online", want.online, got.online);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_tracker();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPEED_ALPHA: alpha = csr_wdata[AlphaW-1:0];
               CSR_TIMEOUT_MS:  timeout = csr_wdata[TimeoutW-1:0];
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) advance_tracker(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) compare_status(rsp_tdata);
      end
      pending = status_expected.size();
   end

endmodule

// File: tb/tb_motor_feedback_tracker.sv
// tb_motor_feedback_tracker: stimulus, register setup, stall control and verdict for the tracker
`timescale 1ns / 1ps

module tb_motor_feedback_tracker;
   import mft_pkg::*;

   localparam logic [FuncW-1:0]     FUNC_NOP   = 2'd3;
   localparam logic [CsrIndexW-1:0] CSR_UNUSED = 2'd3;
   localparam int ResetCycles   = 10;
   localparam int LongHold      = 200;
   localparam int WatchdogLimit = 5000;
   localparam int RandomPhases  = 5;
   localparam int PhaseItems    = 120;
   localparam int BurstItems    = 30;
   localparam int SettleCycles  = 10;

   logic                  clock      = 0;
   logic                  reset      = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [FrameW-1:0]     req_tdata  = '0;
   logic [FuncW-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  csr_valid  = 0;
   logic                  csr_ready;
   logic [CsrIndexW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0]   csr_wdata  = '0;

   int   mismatches;
   int   pending;
   int   idle_cycles = 0;
   bit   no_idle      = 0;
   bit   hold_request = 0;
   int   n_frames = 0;
   int   n_ticks = 0;
   int   n_zero = 0;
   int   n_other = 0;
   int   n_settings = 0;
   logic [15:0] walk_angle = '0;

   always #2 clock = ~clock;

   motor_feedback_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mft_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [FrameW-1:0] pack_frame(input logic [15:0] ang,
                                                     input logic [15:0] spd,
                                                     input logic [15:0] cur,
                                                     input logic [7:0]  temp);
      return {ang, spd, cur, temp};
   endfunction

   initial begin : receiver
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 0;
            repeat (LongHold) @(negedge clock);
            hold_request = 0;
            rsp_tready = 1;
         end else if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   task automatic send_item(input logic [FuncW-1:0] f, input logic [FrameW-1:0] w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = f;
      req_tdata  = w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      case (f)
         FUNC_FRAME: n_frames++;
         FUNC_TICK:  n_ticks++;
         FUNC_ZERO:  n_zero++;
         default:    n_other++;
      endcase
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] val);
      drain();
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_config(input logic [AlphaW-1:0] alpha, input logic [TimeoutW-1:0] tmo);
      write_reg(CSR_SPEED_ALPHA, CsrDataW'(alpha));
      write_reg(CSR_TIMEOUT_MS, tmo);
      n_settings++;
   endtask

   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         // angle walks in steps that straddle half a turn, now and then jumps anywhere
         if ($urandom_range(0, 9) == 0) walk_angle = 16'($urandom);
         else walk_angle = walk_angle + 16'($urandom_range(0, 9000)) - 16'd4500;
         send_item(FUNC_FRAME, pack_frame(walk_angle, 16'($urandom), 16'($urandom),
                                          8'($urandom)));
      end else if (r < 90) begin
         send_item(FUNC_TICK, FrameW'({$urandom, $urandom}));
      end else if (r < 97) begin
         send_item(FUNC_ZERO, FrameW'({$urandom, $urandom}));
      end else begin
         send_item(FUNC_NOP, FrameW'({$urandom, $urandom}));
      end
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // status before any frame
      send_item(FUNC_TICK, '1);
      send_item(FUNC_ZERO, '0);
      send_item(FUNC_NOP, '1);
      // first frame sets the baseline only
      send_item(FUNC_FRAME, pack_frame(16'd8000, 16'h7fff, 16'h8000, 8'hff));
      send_item(FUNC_FRAME, pack_frame(16'd100, 16'h8000, 16'h7fff, 8'h00));
      send_item(FUNC_FRAME, pack_frame(16'd8100, 16'h0000, 16'hffff, 8'h01));
      // exactly half a turn back is kept, one more forward is wrapped
      send_item(FUNC_FRAME, pack_frame(16'd4004, 16'h0001, 16'h0000, 8'h80));
      send_item(FUNC_FRAME, pack_frame(16'd8101, 16'hffff, 16'h0001, 8'h7f));
      // angle words beyond the encoder range
      send_item(FUNC_FRAME, pack_frame(16'hffff, 16'h1234, 16'hedcb, 8'h55));
      send_item(FUNC_FRAME, pack_frame(16'h8000, 16'hedcb, 16'h1234, 8'haa));
      send_item(FUNC_ZERO, '1);
      send_item(FUNC_FRAME, pack_frame(16'h8000, 16'd1, 16'd2, 8'd3));

      write_reg(CSR_UNUSED, 16'hffff);
      // overshooting coefficient drives the filter into saturation, zero timeout
      set_config(9'd511, 16'd0);
      send_item(FUNC_FRAME, pack_frame(16'h8001, 16'h7fff, 16'd0, 8'd20));
      send_item(FUNC_FRAME, pack_frame(16'h8002, 16'h7fff, 16'd0, 8'd21));
      send_item(FUNC_FRAME, pack_frame(16'h8003, 16'h8000, 16'd0, 8'd22));
      send_item(FUNC_FRAME, pack_frame(16'h8004, 16'h8000, 16'd0, 8'd23));
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_FRAME, pack_frame(16'h8005, 16'h0100, 16'd0, 8'd24));
      send_item(FUNC_TICK, '0);

      set_config(9'd0, 16'hffff);
      send_item(FUNC_FRAME, pack_frame(16'd10, 16'h1234, 16'h8000, 8'd30));
      send_item(FUNC_TICK, '1);
      send_item(FUNC_FRAME, pack_frame(16'd20, 16'h8000, 16'h7fff, 8'd31));

      set_config(9'd256, 16'd1);
      send_item(FUNC_FRAME, pack_frame(16'd30, 16'h4321, 16'h0001, 8'd32));
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, '0);

      for (int p = 0; p < RandomPhases; p++) begin
         if ($urandom_range(0, 3) == 0)
            set_config(9'($urandom_range(257, 511)), 16'($urandom_range(0, 20)));
         else
            set_config(9'($urandom_range(0, 256)), 16'($urandom_range(0, 20)));
         no_idle = (p == 2);
         for (int i = 0; i < PhaseItems; i++) send_random_item();
         no_idle = 0;
         if (p == 0) begin
            // receiver holds off while the sender keeps offering items back to back
            drain();
            hold_request = 1;
            no_idle = 1;
            for (int i = 0; i < BurstItems; i++) send_random_item();
            no_idle = 0;
            drain();
         end
      end

      drain();
      repeat (SettleCycles) @(posedge clock);
      $display("covered %0d items: %0d frames, %0d ticks, %0d angle clears, %0d unused codes",
               n_frames + n_ticks + n_zero + n_other, n_frames, n_ticks, n_zero, n_other);
      $display("across %0d register settings, with a long result stall and gap-free stretches",
               n_settings);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
design/mft_pkg.sv
design/mft_in_stage.sv
design/mft_speed_filter.sv
design/mft_core.sv
design/motor_feedback_tracker.sv
tb/mft_status_checker.sv
tb/tb_motor_feedback_tracker.sv
